// ===== design/snm_pkg.sv =====
// ----------------------------------------------------------------------------
// snm_pkg
// Shared types and constants for the spatial node merge table.
// ----------------------------------------------------------------------------
package snm_pkg;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int COORD_BITS  = 20;
	localparam int MAXD_BITS   = 21;
	localparam int RADIUS_BITS = 20;

	localparam logic [9:0] REG_MERGE_RADIUS = 10'd0;

	// request passed from front to back, coordinates at full field width
	typedef struct packed {
		logic              op;
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic signed [20:0] maxd;
		logic              first;
		logic              lastp;
		logic              loop;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [7:0] node_index;
		logic       node_added;
		logic       table_full;
		logic       edge_valid;
		logic [7:0] edge_from;
		logic [7:0] edge_to;
		logic       last;
	} res_t;

endpackage

// ===== design/snm_front.sv =====
// ----------------------------------------------------------------------------
// snm_front
// Input stage and two-entry request queue.
// ----------------------------------------------------------------------------
module snm_front import snm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic q_valid,
	input  logic q_take,
	output req_t q_req
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_req    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== design/snm_back.sv =====
// ----------------------------------------------------------------------------
// snm_back
// Node table, linear nearest scan and result sequencing.
// ----------------------------------------------------------------------------
module snm_back import snm_pkg::*; #(
	parameter int MAX_NODES  = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [RADIUS_BITS-1:0] merge_radius,
	input  logic                   q_valid,
	output logic                   q_take,
	input  req_t                   q_req,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_t                   res
);
	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int CB = COORD_BITS;
	localparam int DW = 2 * CB + 3;

	localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_SCAN = 3'd2, S_DONE = 3'd3,
		S_OUT0 = 3'd4, S_OUT1 = 3'd5;

	logic [2:0]    st_q;
	logic [3*CB-1:0] tab [MAX_NODES];
	logic [3*CB-1:0] rd_q;
	req_t          r_q;
	logic [IW:0]   i_q;
	logic          has_q;
	logic [DW-1:0] best_q;
	logic [IW-1:0] bidx_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] prev_q, pfirst_q;
	logic          prev_v_q, pfirst_v_q;
	logic          unl_q;
	res_t          r0_q, r1_q;
	logic          two_q;
	logic          rd_en;
	logic [IW-1:0] rd_a;
	logic          wr_en;
	logic [IW-1:0] node;

	// squared distance, three multipliers each under 32x32
	logic signed [CB:0] d0, d1, d2;
	logic [CB:0]        a0, a1, a2;
	logic [DW-1:0]      sqd;
	always_comb begin
		d0 = $signed(r_q.x[CB-1:0]) - $signed(rd_q[CB-1:0]);
		d1 = $signed(r_q.y[CB-1:0]) - $signed(rd_q[2*CB-1:CB]);
		d2 = $signed(r_q.z[CB-1:0]) - $signed(rd_q[3*CB-1:2*CB]);
		a0 = d0[CB] ? (CB+1)'(-d0) : d0;
		a1 = d1[CB] ? (CB+1)'(-d1) : d1;
		a2 = d2[CB] ? (CB+1)'(-d2) : d2;
		sqd = DW'(a0 * a0) + DW'(a1 * a1) + DW'(a2 * a2);
	end

	logic scan_more, better;
	assign scan_more = (CW'(i_q) < cnt_q) && (i_q < (IW+1)'(MAX_NODES));
	assign better    = (unl_q && !has_q) || (sqd < best_q);
	assign rd_a      = i_q[IW-1:0];
	assign rd_en     = (st_q == S_RD) || (st_q == S_SCAN);
	assign q_take    = (st_q == S_IDLE) && q_valid;
	assign res_valid = (st_q == S_OUT0) || (st_q == S_OUT1);
	assign res       = (st_q == S_OUT1) ? r1_q : r0_q;
	assign node      = cnt_q[IW-1:0];
	assign wr_en     = (st_q == S_DONE) && !r_q.op && !has_q && (cnt_q < CW'(MAX_NODES));

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= tab[rd_a];
		if (wr_en) tab[node] <= {r_q.z[CB-1:0], r_q.y[CB-1:0], r_q.x[CB-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic          h, add, full, ev, cl, pv, fv;
		logic [IW-1:0] n;
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; prev_q <= '0; prev_v_q <= 1'b0;
			pfirst_q <= '0; pfirst_v_q <= 1'b0; i_q <= '0; has_q <= 1'b0;
			two_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (q_valid) begin
					r_q <= q_req; i_q <= '0; has_q <= 1'b0;
					if (q_req.op == OP_QUERY) begin
						unl_q  <= q_req.maxd[MAXD_BITS-1];
						best_q <= DW'(q_req.maxd[MAXD_BITS-2:0]) * DW'(q_req.maxd[MAXD_BITS-2:0]);
					end else begin
						unl_q  <= 1'b0;
						best_q <= DW'(merge_radius) * DW'(merge_radius);
					end
					st_q <= S_RD;
				end
				S_RD: begin
					i_q <= i_q + 1'b1;
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					// rd_q holds entry i_q-1
					if (CW'(i_q - 1'b1) < cnt_q && (i_q - 1'b1) < (IW+1)'(MAX_NODES) && better)
					begin
						best_q <= sqd; bidx_q <= IW'(i_q - 1'b1); has_q <= 1'b1;
					end
					if (scan_more) i_q <= i_q + 1'b1;
					else st_q <= S_DONE;
				end
				S_DONE: begin
					if (r_q.op == OP_QUERY) begin
						r0_q <= '{found: has_q, node_index: has_q ? 8'(bidx_q) : 8'd0,
							last: 1'b1, default: '0};
						two_q <= 1'b0;
					end else begin
						pv = prev_v_q && !r_q.first;
						fv = pfirst_v_q && !r_q.first;
						h = has_q; n = bidx_q; add = 1'b0; full = 1'b0;
						if (!has_q) begin
							if (cnt_q < CW'(MAX_NODES)) begin
								n = node; add = 1'b1; h = 1'b1; cnt_q <= cnt_q + 1'b1;
							end else full = 1'b1;
						end
						ev = h && pv && (prev_q != n);
						cl = r_q.lastp && r_q.loop && h && (r_q.first ? 1'b1 : fv) &&
							(r_q.first ? 1'b0 : (pfirst_q != n));
						r0_q.found <= h; r0_q.node_index <= h ? 8'(n) : 8'd0;
						r0_q.node_added <= add; r0_q.table_full <= full;
						r0_q.edge_valid <= ev; r0_q.edge_from <= ev ? 8'(prev_q) : 8'd0;
						r0_q.edge_to <= ev ? 8'(n) : 8'd0; r0_q.last <= !cl;
						r1_q <= '{edge_valid: 1'b1, edge_from: 8'(n),
							edge_to: 8'(pfirst_q), last: 1'b1, default: '0};
						two_q <= cl;
						if (h) begin
							prev_q <= n;
							if (r_q.first) pfirst_q <= n;
						end
						prev_v_q <= h && !r_q.lastp;
						pfirst_v_q <= r_q.lastp ? 1'b0 : (r_q.first ? h : pfirst_v_q);
					end
					st_q <= S_OUT0;
				end
				S_OUT0: if (res_ready) st_q <= two_q ? S_OUT1 : S_IDLE;
				S_OUT1: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/spatial_node_merge_table_core.sv =====
// ----------------------------------------------------------------------------
// spatial_node_merge_table_core
// Node table with nearest-neighbor merge and edge reporting.
// A request passes the table read, the scan and a result stage before its first
// result; a closing edge adds a second result. The scan takes one node per
// cycle; the next request starts only once all its results are accepted.
// A two-entry queue takes requests while the scan runs.
// Reset clears counters and path state; node table content is not cleared.
// ----------------------------------------------------------------------------
module spatial_node_merge_table_core import snm_pkg::*; #(
	parameter int MAX_NODES  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation, pos_x, pos_y, pos_z, max_distance, first_point, last_point,
	// loop_path (lowest first), zero fill
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found, node_index, node_added, table_full, edge_valid, edge_from, edge_to
	// (lowest first), zero fill
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [RADIUS_BITS-1:0] radius_q;
	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_take;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'(4 * REG_MERGE_RADIUS)) ? 32'(radius_q) : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= 20'd100;
		else if (psel && penable && pwrite && paddr == 2'(4 * REG_MERGE_RADIUS))
			radius_q <= pwdata[19:0];
	end

	assign in_req = '{op: s_tdata[0], x: s_tdata[20:1], y: s_tdata[40:21],
		z: s_tdata[60:41], maxd: s_tdata[81:61], first: s_tdata[82],
		lastp: s_tdata[83], loop: s_tdata[84]};

	snm_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req, .q_valid, .q_take, .q_req);

	snm_back #(.MAX_NODES(MAX_NODES)) u_back (.clk, .arst_n,
		.merge_radius(radius_q), .q_valid, .q_take, .q_req, .res_valid(m_tvalid),
		.res_ready(m_tready), .res);

	assign m_tdata = {4'b0000, res.edge_to, res.edge_from, res.edge_valid, res.table_full,
		res.node_added, res.node_index, res.found};
	assign m_tlast = res.last;
endmodule
